[sv/pgt_pkg.sv]
`default_nettype none

package pgt_pkg;

  localparam int unsigned Depth = 256;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = AddrW + 1;
  localparam int unsigned ChW   = 8;
  localparam int unsigned ChanN = 3;
  localparam int unsigned ChSelW = $clog2(ChanN);
  localparam int unsigned ColW  = ChanN * ChW;
  localparam int unsigned StepW = $clog2(ChW + 1);
  localparam logic [ChW-1:0] ChMax = '1;

  typedef enum logic [2:0] {
    ACT_READ     = 3'd0,
    ACT_WRITE    = 3'd1,
    ACT_GRAD     = 3'd2,
    ACT_GRAD_INV = 3'd3,
    ACT_MAX      = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FILL,
    ST_MAX,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [ColW-1:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic               done;
    logic signed [ChW:0] quo;
    logic [ChW-1:0]     rem;
  } div_res_t;

endpackage

`default_nettype wire

[sv/palette_gradient_table.sv]
`default_nettype none

// RGB palette of 256 entries, 8 bits per channel, with one result per
// transfer. One item at a time: max reads one entry per cycle through the
// single memory read port, and a gradient of n+1 entries runs three
// serial divides of (end - start) by n on the shared divider, then writes
// one entry per cycle by incremental quotient/remainder stepping. Entries
// never written read as zero. colors_in_use above 256 counts as 256 and
// may only be written while the block is idle.
module palette_gradient_table (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [8:0]          cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [2:0]          action_i,
  input  wire logic [7:0]          first_index_i,
  input  wire logic [7:0]          last_index_i,
  input  wire logic [7:0]          start_red_i,
  input  wire logic [7:0]          start_green_i,
  input  wire logic [7:0]          start_blue_i,
  input  wire logic [7:0]          end_red_i,
  input  wire logic [7:0]          end_green_i,
  input  wire logic [7:0]          end_blue_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [8:0]        read_red_o,
  output logic signed [8:0]        read_green_o,
  output logic signed [8:0]        read_blue_o,
  output logic [7:0]               max_channel_o,
  output logic                     applied_o
);

  localparam int unsigned ChW  = pgt_pkg::ChW;
  localparam int unsigned CntW = pgt_pkg::CntW;
  localparam int unsigned AddrW = pgt_pkg::AddrW;
  localparam int unsigned ChanN = pgt_pkg::ChanN;
  localparam int unsigned ChSelW = pgt_pkg::ChSelW;

  pgt_pkg::state_e state_q, state_d;

  logic [CntW-1:0]   cfg_q;
  logic [CntW-1:0]   count_w;
  logic              accept_w;
  logic              first_ok_w;
  logic              last_ok_w;
  logic              grad_ok_w;

  logic [ChSelW-1:0] ch_q;
  logic [CntW-1:0]   sweep_q;
  logic              pend_q;
  logic              out_valid_q;
  logic              out_load_w;
  logic              sweep_more_w;

  logic [AddrW-1:0]  first_q;
  logic [AddrW-1:0]  last_q;
  logic [AddrW-1:0]  addr_q;
  logic [ChW-1:0]    n_q;
  logic [ChanN-1:0][ChW-1:0] s_q;
  logic [ChanN-1:0][ChW-1:0] e_q;
  logic [ChanN-1:0][ChW:0]   qd_q;
  logic [ChanN-1:0][ChW-1:0] rd_q;
  logic [ChanN-1:0][ChW-1:0] qv_q;
  logic [ChanN-1:0][ChW-1:0] rv_q;
  logic [ChanN-1:0][ChW-1:0] qv_nx_w;
  logic [ChanN-1:0][ChW-1:0] rv_nx_w;

  logic [ChW:0]      res_r_q, res_g_q, res_b_q;
  logic [ChW-1:0]    res_max_q;
  logic              res_app_q;

  pgt_pkg::mem_wr_t  mem_wr_w;
  logic [AddrW-1:0]  rd_addr_w;
  logic [pgt_pkg::ColW-1:0] rd_data_w;

  logic                div_start_w;
  logic signed [ChW:0] div_num_w;
  pgt_pkg::div_res_t   div_res_w;

  logic [ChW-1:0]    rd_r_w, rd_g_w, rd_b_w;
  logic [ChW-1:0]    max_a_w, max_b_w, max_c_w;

  assign count_w  = (cfg_q > CntW'(pgt_pkg::Depth)) ? CntW'(pgt_pkg::Depth) : cfg_q;
  assign accept_w = in_valid_i && in_ready_o;
  assign first_ok_w = {1'b0, first_index_i} < count_w;
  assign last_ok_w  = {1'b0, last_index_i} < count_w;
  assign grad_ok_w  = first_ok_w && last_ok_w && (first_index_i < last_index_i);
  assign sweep_more_w = sweep_q < count_w;
  assign out_load_w = (state_q == pgt_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  assign div_num_w = $signed({1'b0, e_q[ch_q]}) - $signed({1'b0, s_q[ch_q]});

  assign rd_r_w = rd_data_w[3*ChW-1:2*ChW];
  assign rd_g_w = rd_data_w[2*ChW-1:ChW];
  assign rd_b_w = rd_data_w[ChW-1:0];
  assign max_a_w = (rd_r_w > rd_g_w) ? rd_r_w : rd_g_w;
  assign max_b_w = (max_a_w > rd_b_w) ? max_a_w : rd_b_w;
  assign max_c_w = (max_b_w > res_max_q) ? max_b_w : res_max_q;

  // incremental lerp: quotient += floor(d/n), carry when remainder wraps n
  always_comb begin
    logic [ChW:0] rsum;
    logic         cy;
    for (int k = 0; k < ChanN; k++) begin
      rsum = {1'b0, rv_q[k]} + {1'b0, rd_q[k]};
      cy   = rsum >= {1'b0, n_q};
      rv_nx_w[k] = cy ? ChW'(rsum - {1'b0, n_q}) : rsum[ChW-1:0];
      qv_nx_w[k] = qv_q[k] + qd_q[k][ChW-1:0] + {{(ChW-1){1'b0}}, cy};
    end
  end

  pgt_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (mem_wr_w),
    .rd_addr_i (rd_addr_w),
    .rd_data_o (rd_data_w)
  );

  pgt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_w),
    .num_i   (div_num_w),
    .den_i   (n_q),
    .res_o   (div_res_w)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pgt_pkg::ST_IDLE: begin
        if (accept_w) begin
          unique case (action_i) inside
            pgt_pkg::ACT_READ: begin
              state_d = first_ok_w ? pgt_pkg::ST_READ : pgt_pkg::ST_DONE;
            end
            pgt_pkg::ACT_GRAD, pgt_pkg::ACT_GRAD_INV: begin
              state_d = grad_ok_w ? pgt_pkg::ST_DIV_START : pgt_pkg::ST_DONE;
            end
            pgt_pkg::ACT_MAX: state_d = pgt_pkg::ST_MAX;
            default:          state_d = pgt_pkg::ST_DONE;
          endcase
        end
      end
      pgt_pkg::ST_READ:      state_d = pgt_pkg::ST_DONE;
      pgt_pkg::ST_DIV_START: state_d = pgt_pkg::ST_DIV_WAIT;
      pgt_pkg::ST_DIV_WAIT: begin
        if (div_res_w.done) begin
          state_d = (ch_q == ChSelW'(ChanN - 1)) ? pgt_pkg::ST_FILL : pgt_pkg::ST_DIV_START;
        end
      end
      pgt_pkg::ST_FILL: begin
        if (addr_q == last_q) state_d = pgt_pkg::ST_DONE;
      end
      pgt_pkg::ST_MAX: begin
        if (!sweep_more_w && !pend_q) state_d = pgt_pkg::ST_DONE;
      end
      pgt_pkg::ST_DONE: begin
        if (out_load_w) state_d = pgt_pkg::ST_IDLE;
      end
      default: state_d = pgt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == pgt_pkg::ST_IDLE);
    cfg_ready_o   = 1'b1;
    div_start_w   = (state_q == pgt_pkg::ST_DIV_START);
    rd_addr_w     = (state_q == pgt_pkg::ST_MAX) ? sweep_q[AddrW-1:0] : first_index_i;
    mem_wr_w.en   = 1'b0;
    mem_wr_w.addr = first_index_i;
    mem_wr_w.data = {start_red_i, start_green_i, start_blue_i};
    if (state_q == pgt_pkg::ST_FILL) begin
      mem_wr_w.en   = 1'b1;
      mem_wr_w.addr = addr_q;
      mem_wr_w.data = {qv_q[0], qv_q[1], qv_q[2]};
    end else if (accept_w && action_i == pgt_pkg::ACT_WRITE && first_ok_w) begin
      mem_wr_w.en   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pgt_pkg::ST_IDLE;
      cfg_q       <= CntW'(pgt_pkg::Depth);
      ch_q        <= '0;
      sweep_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      if (state_q == pgt_pkg::ST_IDLE) begin
        ch_q    <= '0;
        sweep_q <= '0;
        pend_q  <= 1'b0;
      end
      if (state_q == pgt_pkg::ST_DIV_WAIT && div_res_w.done &&
          ch_q != ChSelW'(ChanN - 1)) begin
        ch_q <= ch_q + 1'b1;
      end
      if (state_q == pgt_pkg::ST_MAX) begin
        pend_q <= sweep_more_w;
        if (sweep_more_w) sweep_q <= sweep_q + 1'b1;
      end
      if (out_load_w) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      first_q   <= first_index_i;
      last_q    <= last_index_i;
      n_q       <= last_index_i - first_index_i;
      s_q       <= {start_blue_i, start_green_i, start_red_i};
      if (action_i == pgt_pkg::ACT_GRAD_INV) begin
        e_q <= {pgt_pkg::ChMax - start_blue_i, pgt_pkg::ChMax - start_green_i,
                pgt_pkg::ChMax - start_red_i};
      end else begin
        e_q <= {end_blue_i, end_green_i, end_red_i};
      end
      res_r_q   <= '0;
      res_g_q   <= '0;
      res_b_q   <= '0;
      res_max_q <= '0;
      res_app_q <= 1'b0;
      case (action_i) inside
        pgt_pkg::ACT_READ: begin
          if (!first_ok_w) begin
            res_r_q <= '1;
            res_g_q <= '1;
            res_b_q <= '1;
          end
        end
        pgt_pkg::ACT_WRITE:                       res_app_q <= first_ok_w;
        pgt_pkg::ACT_GRAD, pgt_pkg::ACT_GRAD_INV: res_app_q <= grad_ok_w;
        pgt_pkg::ACT_MAX:                         res_app_q <= 1'b1;
        default:                                  res_app_q <= 1'b0;
      endcase
    end
    if (state_q == pgt_pkg::ST_READ) begin
      res_r_q   <= {1'b0, rd_r_w};
      res_g_q   <= {1'b0, rd_g_w};
      res_b_q   <= {1'b0, rd_b_w};
      res_app_q <= 1'b1;
    end
    if (state_q == pgt_pkg::ST_DIV_WAIT && div_res_w.done) begin
      qd_q[ch_q] <= div_res_w.quo;
      rd_q[ch_q] <= div_res_w.rem;
      if (ch_q == ChSelW'(ChanN - 1)) begin
        qv_q   <= s_q;
        rv_q   <= '0;
        addr_q <= first_q;
      end
    end
    if (state_q == pgt_pkg::ST_FILL) begin
      qv_q   <= qv_nx_w;
      rv_q   <= rv_nx_w;
      addr_q <= addr_q + 1'b1;
    end
    if (state_q == pgt_pkg::ST_MAX && pend_q) begin
      res_max_q <= max_c_w;
    end
    if (out_load_w) begin
      read_red_o    <= res_r_q;
      read_green_o  <= res_g_q;
      read_blue_o   <= res_b_q;
      max_channel_o <= res_max_q;
      applied_o     <= res_app_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[sv/pgt_mem.sv]
`default_nettype none

module pgt_mem (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire pgt_pkg::mem_wr_t                wr_i,
  input  wire logic [pgt_pkg::AddrW-1:0]       rd_addr_i,
  output logic      [pgt_pkg::ColW-1:0]        rd_data_o
);

  logic [pgt_pkg::ColW-1:0]  mem_q [pgt_pkg::Depth];
  logic [pgt_pkg::Depth-1:0] vld_q;
  logic [pgt_pkg::ColW-1:0]  data_q;
  logic                      vld_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    data_q <= mem_q[rd_addr_i];
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      vld_rd_q <= vld_q[rd_addr_i];
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = vld_rd_q ? data_q : '0;

endmodule

`default_nettype wire

[sv/pgt_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle, floor semantics on a signed
// numerator so the remainder always lands in [0, den).
module pgt_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic signed [pgt_pkg::ChW:0]    num_i,
  input  wire logic [pgt_pkg::ChW-1:0]         den_i,
  output pgt_pkg::div_res_t                    res_o
);

  logic                        busy_q;
  logic [pgt_pkg::StepW-1:0]   step_q;
  logic [pgt_pkg::ChW-1:0]     dv_q;
  logic [pgt_pkg::ChW-1:0]     rem_q;
  logic                        neg_q;
  logic [pgt_pkg::ChW:0]       abs_w;
  logic [pgt_pkg::ChW:0]       trial_w;
  logic [pgt_pkg::ChW:0]       diff_w;
  logic                        ge_w;
  logic [pgt_pkg::ChW:0]       q_ext_w;

  assign abs_w   = num_i[pgt_pkg::ChW] ? (~num_i + 1'b1) : num_i;
  assign trial_w = {rem_q, dv_q[pgt_pkg::ChW-1]};
  assign ge_w    = trial_w >= {1'b0, den_i};
  assign diff_w  = trial_w - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      if (step_q != pgt_pkg::StepW'(pgt_pkg::ChW)) begin
        step_q <= step_q + 1'b1;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dv_q  <= abs_w[pgt_pkg::ChW-1:0];
      rem_q <= '0;
      neg_q <= num_i[pgt_pkg::ChW];
    end else if (busy_q && step_q != pgt_pkg::StepW'(pgt_pkg::ChW)) begin
      rem_q <= ge_w ? diff_w[pgt_pkg::ChW-1:0] : trial_w[pgt_pkg::ChW-1:0];
      dv_q  <= {dv_q[pgt_pkg::ChW-2:0], ge_w};
    end
  end

  assign q_ext_w = {1'b0, dv_q};

  always_comb begin
    res_o.done = busy_q && (step_q == pgt_pkg::StepW'(pgt_pkg::ChW));
    if (neg_q && rem_q != '0) begin
      // floor(-a/n) = -(Q+1), remainder n - R
      res_o.quo = ~q_ext_w;
      res_o.rem = den_i - rem_q;
    end else if (neg_q) begin
      res_o.quo = ~q_ext_w + 1'b1;
      res_o.rem = '0;
    end else begin
      res_o.quo = q_ext_w;
      res_o.rem = rem_q;
    end
  end

endmodule

`default_nettype wire
